/* hw/rtl/pwkf_pkg.sv */
// Package for the pulse-width key frame decoder.
// Holds the register map, reset values, shared types and the window compare.
// No dependencies.
package pwkf_pkg;

	localparam int unsigned IntervalW = 16;
	localparam int unsigned KeyW = 4;
	localparam int unsigned DataBits = 8;
	localparam int unsigned BitIdxW = 4;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [IntervalW-1:0] StartMinRst = 16'd4000;
	localparam logic [IntervalW-1:0] StartMaxRst = 16'd6000;
	localparam logic [IntervalW-1:0] OneMinRst = 16'd1500;
	localparam logic [IntervalW-1:0] OneMaxRst = 16'd2500;

	typedef enum logic [CfgIdxW-1:0] {
		REG_START_MIN = 2'd0,
		REG_START_MAX = 2'd1,
		REG_ONE_MIN   = 2'd2,
		REG_ONE_MAX   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [IntervalW-1:0] start_min;
		logic [IntervalW-1:0] start_max;
		logic [IntervalW-1:0] one_min;
		logic [IntervalW-1:0] one_max;
	} cfg_t;

	typedef struct packed {
		logic            frame_error;
		logic [KeyW-1:0] keys_held;
		logic [KeyW-1:0] keys_pressed;
	} result_t;

	function automatic logic strictly_inside(
		input logic [IntervalW-1:0] v,
		input logic [IntervalW-1:0] lo,
		input logic [IntervalW-1:0] hi
	);
		return (v > lo) && (v < hi);
	endfunction

endpackage

/* hw/rtl/pwkf_cfg.sv */
// Configuration register bank for the pulse-width key frame decoder.
// Depends on pwkf_pkg for the register map and reset values.
module pwkf_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pwkf_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [pwkf_pkg::IntervalW-1:0]   cfg_wdata,
	output pwkf_pkg::cfg_t                   cfg
);
	import pwkf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min <= StartMinRst;
			cfg_q.start_max <= StartMaxRst;
			cfg_q.one_min <= OneMinRst;
			cfg_q.one_max <= OneMaxRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_MIN: cfg_q.start_min <= cfg_wdata;
				REG_START_MAX: cfg_q.start_max <= cfg_wdata;
				REG_ONE_MIN:   cfg_q.one_min <= cfg_wdata;
				REG_ONE_MAX:   cfg_q.one_max <= cfg_wdata;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/pwkf_core.sv */
// Input register, frame state and bit decode for the key frame decoder.
// Depends on pwkf_pkg for types and the window compare.
module pwkf_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pwkf_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pwkf_pkg::IntervalW-1:0] edge_interval,
	input  logic                           out_free,
	output logic                           res_load,
	output pwkf_pkg::result_t              res
);
	import pwkf_pkg::*;

	logic                 valid_s1;
	logic [IntervalW-1:0] interval_s1;

	logic                 armed_q;
	logic [BitIdxW-1:0]   bit_idx_q;
	logic [DataBits-1:0]  shift_q;
	logic [KeyW-1:0]      held_q;
	logic [KeyW-1:0]      pressed_q;

	logic                 emit_s1;
	logic                 adv;
	logic                 hit_start;
	logic                 hit_one;
	logic [KeyW-1:0]      lo;
	logic [KeyW-1:0]      hi;
	logic                 err;

	assign hit_start = strictly_inside(interval_s1, cfg.start_min, cfg.start_max);
	assign hit_one = strictly_inside(interval_s1, cfg.one_min, cfg.one_max);

	assign emit_s1 = valid_s1 && armed_q && bit_idx_q[BitIdxW-1];
	assign adv = valid_s1 && (!emit_s1 || out_free);
	assign in_ready = !valid_s1 || adv;

	assign lo = shift_q[KeyW-1:0];
	assign hi = shift_q[DataBits-1:KeyW];
	assign err = (hi != ~lo);

	assign res_load = adv && emit_s1;
	assign res.frame_error = err;
	assign res.keys_held = err ? held_q : lo;
	assign res.keys_pressed = err ? pressed_q : (lo & ~held_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			interval_s1 <= edge_interval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			bit_idx_q <= '0;
			shift_q <= '0;
			held_q <= '0;
			pressed_q <= '0;
		end else if (adv) begin
			if (!armed_q) begin
				armed_q <= hit_start;
			end else if (!bit_idx_q[BitIdxW-1]) begin
				shift_q[bit_idx_q[BitIdxW-2:0]] <= hit_one;
				bit_idx_q <= bit_idx_q + 1'b1;
			end else begin
				armed_q <= 1'b0;
				bit_idx_q <= '0;
				held_q <= res.keys_held;
				pressed_q <= res.keys_pressed;
			end
		end
	end

endmodule

/* hw/rtl/pwkf_out.sv */
// Result register on the output channel of the key frame decoder.
// Depends on pwkf_pkg for the result type.
module pwkf_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      res_load,
	input  pwkf_pkg::result_t         res,
	output logic                      out_free,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      frame_error,
	output logic [pwkf_pkg::KeyW-1:0] keys_held,
	output logic [pwkf_pkg::KeyW-1:0] keys_pressed
);
	import pwkf_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign frame_error = res_q.frame_error;
	assign keys_held = res_q.keys_held;
	assign keys_pressed = res_q.keys_pressed;

endmodule

/* hw/rtl/pulse_width_key_frame_decoder.sv */
// Top level of the pulse-width key frame decoder.
// Instantiates pwkf_cfg, pwkf_core and pwkf_out; depends on pwkf_pkg.
//
// Each input item is one measured interval between rising edges of the key
// line. While idle, an interval strictly inside the start window arms a frame.
// The next eight intervals are data bits, LSB first, a 1 when strictly inside
// the one window. The ninth interval closes the frame and yields one result
// item with the complement check flag and the held and pressed key masks.
// Intervals that do not close a frame yield no result.
// With a free result register, a closing item is accepted into the input
// register and its result item is then loaded into the result register,
// where it is presented as valid. One item is accepted per cycle while no
// closing item waits in the input register for the result register to free.
// When the receiver stalls, the result register holds its item; items that
// yield no result keep flowing, and a closing item waits in the input register
// until the result register frees, and input stops while it waits.
// Reset clears the frame state and key masks, empties both registers and loads
// the window registers with their default values. The user must write window
// registers only while no item is in flight; the block does not enforce this.
module pulse_width_key_frame_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pwkf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pwkf_pkg::IntervalW-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pwkf_pkg::IntervalW-1:0] edge_interval,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           frame_error,
	output logic [pwkf_pkg::KeyW-1:0]      keys_held,
	output logic [pwkf_pkg::KeyW-1:0]      keys_pressed
);
	import pwkf_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    res_load;
	logic    out_free;

	pwkf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pwkf_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.edge_interval (edge_interval),
		.out_free      (out_free),
		.res_load      (res_load),
		.res           (res)
	);

	pwkf_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_load     (res_load),
		.res          (res),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_error  (frame_error),
		.keys_held    (keys_held),
		.keys_pressed (keys_pressed)
	);

endmodule

/* hw/rtl/pwkf_checker.sv */
// Port-level checks for the pulse-width key frame decoder.
// Bound to pulse_width_key_frame_decoder; depends on pwkf_pkg.
module pwkf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      frame_error,
	input logic [pwkf_pkg::KeyW-1:0] keys_held,
	input logic [pwkf_pkg::KeyW-1:0] keys_pressed
);
	import pwkf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({frame_error, keys_held, keys_pressed}))
		else $error("Stalled result item changed or dropped.");

	a_pressed_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((keys_pressed & ~keys_held) == '0))
		else $error("Pressed key reported that is not held.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled while the result register is empty.");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("Result item present right after reset.");

endmodule

bind pulse_width_key_frame_decoder pwkf_checker u_pwkf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.frame_error  (frame_error),
	.keys_held    (keys_held),
	.keys_pressed (keys_pressed)
);
